/* rtl/core/mbrot_pkg.sv */
// ----------------------------------------------------------------------------
// mbrot_pkg
// Types, constants and helper functions for the escape-time pixel unit.
// ----------------------------------------------------------------------------
package mbrot_pkg;

  // geometry and fixed-point format
  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS  = 26;
  localparam int DATA_W     = 32;
  localparam int STEP_W     = 31;
  localparam int CNT_W      = 8;
  localparam int COLOR_W    = 32;
  localparam int CFG_IDX_W  = 3;

  // shared multiplier: 33x33 signed covers both 32-bit signed and 31-bit unsigned operands
  localparam int MUL_W  = DATA_W + 1;
  localparam int PROD_W = 2 * MUL_W;
  // floored product after dropping the fraction bits
  localparam int SQ_W   = PROD_W - FRAC_BITS;
  // squared magnitude and threshold compare width
  localparam int ACC_W  = SQ_W + 2;
  // wide intermediate for sums before saturation
  localparam int WIDE_W = 64;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEFT_X    = 3'd0,
    CFG_TOP_Y     = 3'd1,
    CFG_STEP_X    = 3'd2,
    CFG_STEP_Y    = 3'd3,
    CFG_THRESHOLD = 3'd4,
    CFG_MAX_ITER  = 3'd5
  } mbrot_cfg_e;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_CX,
    ST_MUL_CY,
    ST_LOAD,
    ST_SQ_X,
    ST_SQ_Y,
    ST_MUL_XY,
    ST_UPDATE
  } mbrot_state_e;

  // multiplier operand selection
  typedef enum logic [2:0] {
    MSEL_CX,
    MSEL_CY,
    MSEL_XX,
    MSEL_YY,
    MSEL_XY
  } mbrot_msel_e;

  // input beat
  typedef struct packed {
    logic [COORD_BITS-1:0] column;
    logic [COORD_BITS-1:0] row;
  } mbrot_in_t;

  // result beat
  typedef struct packed {
    logic [CNT_W-1:0]   count;
    logic [COLOR_W-1:0] color;
  } mbrot_out_t;

  // saturate a wide signed value to 32 bits
  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    hi = WIDE_W'(32'sh7FFF_FFFF);
    lo = -WIDE_W'(32'sh7FFF_FFFF) - WIDE_W'(1);
    if (v > hi) begin
      return DATA_W'(hi);
    end else if (v < lo) begin
      return DATA_W'(lo);
    end
    return DATA_W'(v);
  endfunction

  // v mod 255 for v below 4096: fold the high nibble back in, then fix 255
  function automatic logic [7:0] mod255(input logic [11:0] v);
    logic [8:0] s;
    logic [7:0] s2;
    s  = 9'(v[7:0]) + 9'(v[11:8]);
    s2 = s[7:0] + 8'(s[8]);
    if (s2 == 8'hFF) begin
      return 8'h00;
    end
    return s2;
  endfunction

  // ARGB palette from the step count
  function automatic logic [COLOR_W-1:0] palette(input logic [CNT_W-1:0] cnt);
    logic [11:0] c12;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    c12 = 12'(cnt);
    r   = mod255(c12);
    g   = mod255(12'(c12 * 12'd7));
    b   = mod255(12'(c12 * 12'd13));
    return {8'hFF, r, g, b};
  endfunction

endpackage

/* rtl/core/mandelbrot_escape_time_top.sv */
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_top
// Escape-time pixel unit: maps column/row to c, iterates z = z^2 + c on one
// shared 33x33 multiplier and returns the step count with its ARGB colour.
// ----------------------------------------------------------------------------
//  channel  | signals                                   | handshake
//  ---------+-------------------------------------------+--------------------
//  input    | start, busy, item_i                       | start && !busy
//  result   | done_o, result_o                          | done_o, one cycle
//  config   | cfg_valid_i, cfg_ready_o, cfg_index_i,    | valid && ready
//           | cfg_data_i                                |
//
//  the result beat comes from ST_LOAD when the step limit is zero, else from
//  ST_UPDATE of the last step; each step runs ST_SQ_X, ST_SQ_Y, ST_MUL_XY
//  and ST_UPDATE; every multiply goes through the one multiplier, three per
//  step; busy is low again the cycle after the result beat
//  reset clears the sequencer and loads the default window; no clearing pass
//  the result cannot be held off, so the unit never stalls on its output
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // pixel channel
  input  logic                            start,
  output logic                            busy,
  input  mbrot_pkg::mbrot_in_t            item_i,
  // result channel
  output logic                            done_o,
  output mbrot_pkg::mbrot_out_t           result_o,
  // configuration channel
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [mbrot_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [mbrot_pkg::DATA_W-1:0]    cfg_data_i
);
  import mbrot_pkg::*;

  // configuration registers
  logic signed [DATA_W-1:0] left_x_q;
  logic signed [DATA_W-1:0] top_y_q;
  logic [STEP_W-1:0]        step_x_q;
  logic [STEP_W-1:0]        step_y_q;
  logic [STEP_W-1:0]        thresh_q;
  logic [CNT_W-1:0]         max_iter_q;

  // sequencer
  mbrot_state_e state_q, state_d;
  mbrot_msel_e  msel;

  // datapath
  logic [COORD_BITS-1:0]    col_q, row_q;
  logic [CNT_W-1:0]         limit_q;
  logic [CNT_W-1:0]         count_q;
  logic signed [DATA_W-1:0] cx_q, cy_q, x_q, y_q;
  logic signed [SQ_W-1:0]   x2_q, y2_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic signed [SQ_W-1:0]   prod_fl;
  logic signed [ACC_W-1:0]  mag;
  logic                     escaped;
  logic signed [DATA_W-1:0] cx_new, cy_new, x_new, y_new;
  logic                     last_step;

  assign cfg_ready_o = 1'b1;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_x_q   <= -32'sd157705830;
      top_y_q    <= -32'sd117440512;
      step_x_q   <= 31'd293601;
      step_y_q   <= 31'd391468;
      thresh_q   <= 31'd671088640;
      max_iter_q <= 8'd255;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_LEFT_X:    left_x_q   <= cfg_data_i;
        CFG_TOP_Y:     top_y_q    <= cfg_data_i;
        CFG_STEP_X:    step_x_q   <= cfg_data_i[STEP_W-1:0];
        CFG_STEP_Y:    step_y_q   <= cfg_data_i[STEP_W-1:0];
        CFG_THRESHOLD: thresh_q   <= cfg_data_i[STEP_W-1:0];
        CFG_MAX_ITER:  max_iter_q <= cfg_data_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // shared multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (msel)
      MSEL_CX: begin
        mul_a = $signed(MUL_W'(col_q));
        mul_b = $signed(MUL_W'(step_x_q));
      end
      MSEL_CY: begin
        mul_a = $signed(MUL_W'(row_q));
        mul_b = $signed(MUL_W'(step_y_q));
      end
      MSEL_XX: begin
        mul_a = MUL_W'(x_q);
        mul_b = MUL_W'(x_q);
      end
      MSEL_YY: begin
        mul_a = MUL_W'(y_q);
        mul_b = MUL_W'(y_q);
      end
      MSEL_XY: begin
        mul_a = MUL_W'(x_q);
        mul_b = MUL_W'(y_q);
      end
      default: ;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // floored product and step arithmetic
  assign prod_fl = SQ_W'(prod_q >>> FRAC_BITS);
  assign mag     = ACC_W'(x2_q) + ACC_W'(y2_q);
  assign escaped = mag > $signed(ACC_W'(thresh_q));
  assign cx_new  = sat32(WIDE_W'(left_x_q) + $signed(prod_q[WIDE_W-1:0]));
  assign cy_new  = sat32(WIDE_W'(top_y_q) + $signed(prod_q[WIDE_W-1:0]));
  assign x_new   = sat32(WIDE_W'(x2_q) - WIDE_W'(y2_q) + WIDE_W'(cx_q));
  assign y_new   = sat32((WIDE_W'(prod_fl) <<< 1) + WIDE_W'(cy_q));
  assign last_step = (count_q + CNT_W'(1)) == limit_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (start) state_d = ST_MUL_CX;
      ST_MUL_CX: state_d = ST_MUL_CY;
      ST_MUL_CY: state_d = ST_LOAD;
      ST_LOAD:   state_d = (limit_q == '0) ? ST_IDLE : ST_SQ_X;
      ST_SQ_X:   state_d = ST_SQ_Y;
      ST_SQ_Y:   state_d = ST_MUL_XY;
      ST_MUL_XY: state_d = ST_UPDATE;
      ST_UPDATE: state_d = (escaped || last_step) ? ST_IDLE : ST_SQ_X;
      default:   state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    busy   = 1'b1;
    done_o = 1'b0;
    msel   = MSEL_XX;
    unique case (state_q)
      ST_IDLE:   busy   = 1'b0;
      ST_MUL_CX: msel   = MSEL_CX;
      ST_MUL_CY: msel   = MSEL_CY;
      ST_LOAD:   done_o = (limit_q == '0);
      ST_SQ_X:   msel   = MSEL_XX;
      ST_SQ_Y:   msel   = MSEL_YY;
      ST_MUL_XY: msel   = MSEL_XY;
      ST_UPDATE: done_o = escaped || last_step;
      default:   busy   = 1'b1;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    prod_q <= mul_p;
    case (state_q)
      ST_IDLE: begin
        col_q   <= item_i.column;
        row_q   <= item_i.row;
        limit_q <= max_iter_q;
        count_q <= '0;
      end
      ST_MUL_CY: cx_q <= cx_new;
      ST_LOAD: begin
        cy_q <= cy_new;
        x_q  <= cx_q;
        y_q  <= cy_new;
      end
      ST_SQ_Y:   x2_q <= prod_fl;
      ST_MUL_XY: y2_q <= prod_fl;
      ST_UPDATE: begin
        if (!escaped) begin
          count_q <= count_q + CNT_W'(1);
          x_q     <= x_new;
          y_q     <= y_new;
        end
      end
      default: ;
    endcase
  end

  // result beat: count as it stands after the last step
  always_comb begin
    result_o.count = (state_q == ST_UPDATE && !escaped) ? count_q + CNT_W'(1) : count_q;
    result_o.color = palette(result_o.count);
  end

`ifndef SYNTHESIS
  // an accepted beat starts the sequencer
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted beat did not start the sequencer");

  // a result frees the unit on the next cycle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy)
    else $error("unit still busy after result beat");

  // the count never passes the latched step limit
  a_count_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (result_o.count <= limit_q))
    else $error("count beyond step limit");

  // floored squares are never negative at the compare
  a_sq_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPDATE) |-> (!x2_q[SQ_W-1] && !y2_q[SQ_W-1]))
    else $error("negative square at the escape compare");
`endif

endmodule

/* test/mbrot_pixel_checker.sv */
// ----------------------------------------------------------------------------
// mbrot_pixel_checker
// Watches the pixel, result and configuration channels of the escape-time
// unit. It keeps its own copy of the window registers and works out the step
// count and ARGB colour of every pixel beat taken in. Result beats are
// compared in order against those predictions, and the failures are counted.
// ----------------------------------------------------------------------------
module mbrot_pixel_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // pixel channel
  input  logic                            start_i,
  input  logic                            busy_i,
  input  mbrot_pkg::mbrot_in_t            item_i,
  // result channel
  input  logic                            done_i,
  input  mbrot_pkg::mbrot_out_t           result_i,
  // configuration channel
  input  logic                            cfg_valid_i,
  input  logic                            cfg_ready_i,
  input  logic [mbrot_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [mbrot_pkg::DATA_W-1:0]    cfg_data_i,
  // status towards the testbench top
  output int                              fail_count_o,
  output int                              pending_o,
  output int                              checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint   SAT_HI      = 64'sd2147483647;
  localparam longint   SAT_LO      = -64'sd2147483648;
  localparam logic [7:0] ALPHA     = 8'hFF;
  localparam int       MAX_REPORTS = 10;

  // window registers as the unit should hold them
  logic signed [mbrot_pkg::DATA_W-1:0] win_left_x;
  logic signed [mbrot_pkg::DATA_W-1:0] win_top_y;
  logic [mbrot_pkg::STEP_W-1:0]        win_step_x;
  logic [mbrot_pkg::STEP_W-1:0]        win_step_y;
  logic [mbrot_pkg::STEP_W-1:0]        win_threshold;
  logic [mbrot_pkg::CNT_W-1:0]         win_max_iter;

  // predicted pixels, oldest first
  mbrot_pkg::mbrot_out_t pending_pixels[$];
  int                    mismatches;
  int                    checked;

  // clamp to the signed 32-bit range
  function automatic longint clamp32(input longint v);
    if (v > SAT_HI) begin
      return SAT_HI;
    end
    if (v < SAT_LO) begin
      return SAT_LO;
    end
    return v;
  endfunction

  // fixed-point product, fraction bits dropped with floor
  function automatic longint fx_mul(input longint a, input longint b);
    return (a * b) >>> mbrot_pkg::FRAC_BITS;
  endfunction

  // escape-time count and palette colour of one pixel
  function automatic mbrot_pkg::mbrot_out_t predict_pixel(input mbrot_pkg::mbrot_in_t px);
    longint                cx;
    longint                cy;
    longint                zx;
    longint                zy;
    longint                xx;
    longint                yy;
    longint                xy;
    int                    n;
    int                    steps;
    bit                    escaped;
    int                    red;
    int                    green;
    int                    blue;
    mbrot_pkg::mbrot_out_t res;
    cx = clamp32(longint'(win_left_x) + longint'(px.column) * longint'(win_step_x));
    cy = clamp32(longint'(win_top_y) + longint'(px.row) * longint'(win_step_y));
    zx = cx;
    zy = cy;
    steps = 0;
    escaped = 1'b0;
    for (n = 0; n < int'(win_max_iter) && !escaped; n++) begin
      xx = fx_mul(zx, zx);
      yy = fx_mul(zy, zy);
      xy = fx_mul(zx, zy);
      if (xx + yy > longint'(win_threshold)) begin
        escaped = 1'b1;
      end else begin
        steps++;
        zx = clamp32(xx - yy + cx);
        zy = clamp32(2 * xy + cy);
      end
    end
    red   = steps % 255;
    green = (steps * 7) % 255;
    blue  = (steps * 13) % 255;
    res.count = steps[7:0];
    res.color = {ALPHA, red[7:0], green[7:0], blue[7:0]};
    return res;
  endfunction

  // register writes, result compare, pixel prediction
  always @(posedge clk_i or negedge rst_ni) begin : watch
    mbrot_pkg::mbrot_out_t want;
    if (!rst_ni) begin
      win_left_x    = -32'sd157705830;
      win_top_y     = -32'sd117440512;
      win_step_x    = 31'd293601;
      win_step_y    = 31'd391468;
      win_threshold = 31'd671088640;
      win_max_iter  = 8'd255;
      pending_pixels.delete();
      mismatches    = 0;
      checked       = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
      checked_o    <= 0;
    end else begin
      // configuration beat
      if (cfg_valid_i && cfg_ready_i) begin
        case (mbrot_pkg::mbrot_cfg_e'(cfg_index_i))
          mbrot_pkg::CFG_LEFT_X:    win_left_x    = cfg_data_i;
          mbrot_pkg::CFG_TOP_Y:     win_top_y     = cfg_data_i;
          mbrot_pkg::CFG_STEP_X:    win_step_x    = cfg_data_i[mbrot_pkg::STEP_W-1:0];
          mbrot_pkg::CFG_STEP_Y:    win_step_y    = cfg_data_i[mbrot_pkg::STEP_W-1:0];
          mbrot_pkg::CFG_THRESHOLD: win_threshold = cfg_data_i[mbrot_pkg::STEP_W-1:0];
          mbrot_pkg::CFG_MAX_ITER:  win_max_iter  = cfg_data_i[mbrot_pkg::CNT_W-1:0];
          default: ;
        endcase
      end

      // result beat against the oldest prediction
      if (done_i) begin
        if (pending_pixels.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("%0t: result with nothing pending: count=%0d color=%08h",
                     $time, result_i.count, result_i.color);
          end
        end else begin
          want = pending_pixels.pop_front();
          checked++;
          if (result_i.count !== want.count || result_i.color !== want.color) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $display("%0t: pixel mismatch: count exp %0d got %0d, color exp %08h got %08h",
                       $time, want.count, result_i.count, want.color, result_i.color);
            end
          end
        end
      end

      // pixel beat taken in
      if (start_i && !busy_i) begin
        pending_pixels.push_back(predict_pixel(item_i));
      end

      fail_count_o <= mismatches;
      pending_o    <= pending_pixels.size();
      checked_o    <= checked;
    end
  end

endmodule

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Regression for the escape-time pixel unit. Directed pixels hit the corners
// of the image, points inside the set, a zero iteration limit, saturating
// coordinates and a zero threshold; then random pixels run under a series of
// random windows, both near the set and fully random, with idle bursts.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mbrot_pkg::*;

  localparam int CLK_PERIOD    = 10;
  localparam int RESET_CYCLES  = 4;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 60;
  localparam int SLOWEST_ITEM  = 4 + 4 * 256;
  localparam int TOTAL_ITEMS   = 20 + RANDOM_PHASES * PHASE_ITEMS;
  localparam int CYCLE_LIMIT   = 3 * TOTAL_ITEMS * (SLOWEST_ITEM + 6) + 10000;
  localparam int DRAIN_CYCLES  = 16;
  localparam logic [COORD_BITS-1:0] COORD_MAX = '1;
  localparam int FX_ONE        = 1 << FRAC_BITS;

  // window after reset
  localparam int DEF_LEFT_X    = -157705830;
  localparam int DEF_TOP_Y     = -117440512;
  localparam int DEF_STEP_X    = 293601;
  localparam int DEF_STEP_Y    = 391468;
  localparam int DEF_THRESHOLD = 671088640;

  localparam logic [DATA_W-1:0]    S32_MAX  = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0]    S32_MIN  = 32'h8000_0000;
  localparam logic [DATA_W-1:0]    STEP_MAX = 32'h7FFF_FFFF;
  // indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  logic                 clk_i     = 1'b0;
  logic                 rst_ni    = 1'b0;
  logic                 start     = 1'b0;
  logic                 busy;
  mbrot_in_t            item      = '0;
  logic                 done;
  mbrot_out_t           result;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0]    cfg_data  = '0;

  int fail_count;
  int pending;
  int checked;
  int pixels_sent = 0;
  int windows_set = 1;
  int idle_pct    = 30;
  int cycles      = 0;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  mandelbrot_escape_time_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .item_i      (item),
    .done_o      (done),
    .result_o    (result),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  mbrot_pixel_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_i       (busy),
    .item_i       (item),
    .done_i       (done),
    .result_i     (result),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  // one configuration beat; valid stays up for back-to-back writes
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready);
  endtask

  // whole window; unused upper data bits carry noise
  task automatic program_window(input logic [DATA_W-1:0] lx, input logic [DATA_W-1:0] ty,
                                input logic [DATA_W-1:0] sx, input logic [DATA_W-1:0] sy,
                                input logic [DATA_W-1:0] thr, input logic [CNT_W-1:0] iters);
    logic [DATA_W-1:0] noise;
    noise = $urandom;
    write_reg(CFG_LEFT_X, lx);
    write_reg(CFG_TOP_Y, ty);
    write_reg(CFG_STEP_X, {noise[31], sx[STEP_W-1:0]});
    write_reg(CFG_STEP_Y, {noise[30], sy[STEP_W-1:0]});
    write_reg(CFG_THRESHOLD, {noise[29], thr[STEP_W-1:0]});
    write_reg(CFG_MAX_ITER, {noise[23:0], iters});
    cfg_valid <= 1'b0;
    windows_set++;
  endtask

  // one pixel beat, maybe after an idle burst
  task automatic send_pixel(input logic [COORD_BITS-1:0] col, input logic [COORD_BITS-1:0] row);
    int gap;
    gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 5) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      // let the unit go idle so the burst is seen on the input side
      do @(posedge clk_i); while (busy);
      repeat (gap - 1) @(posedge clk_i);
    end
    start <= 1'b1;
    item  <= '{column: col, row: row};
    do @(posedge clk_i); while (busy);
    pixels_sent++;
  endtask

  // hold off until every pixel has its result and the unit is idle
  task automatic drain_pixels();
    start <= 1'b0;
    do @(posedge clk_i); while (pending != 0 || busy);
  endtask

  initial begin : stimulus
    logic [DATA_W-1:0] lx;
    logic [DATA_W-1:0] ty;
    logic [DATA_W-1:0] sx;
    logic [DATA_W-1:0] sy;
    logic [DATA_W-1:0] thr;
    logic [CNT_W-1:0]  iters;
    int                ph;
    int                k;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset window: corners, bit patterns, two points inside the set
    send_pixel(12'd0, 12'd0);
    send_pixel(COORD_MAX, COORD_MAX);
    send_pixel(12'd0, COORD_MAX);
    send_pixel(COORD_MAX, 12'd0);
    send_pixel(12'hAAA, 12'h555);
    send_pixel(12'h555, 12'hAAA);
    send_pixel(12'd400, 12'd300);
    send_pixel(12'd480, 12'd300);
    drain_pixels();

    // zero iteration limit
    program_window(DEF_LEFT_X, DEF_TOP_Y, DEF_STEP_X, DEF_STEP_Y, DEF_THRESHOLD, 8'd0);
    send_pixel(12'd400, 12'd300);
    send_pixel(12'd0, 12'd0);
    send_pixel(COORD_MAX, COORD_MAX);
    drain_pixels();

    // coordinate sums clamp at the high end
    program_window(S32_MAX, S32_MIN, STEP_MAX, STEP_MAX, STEP_MAX, 8'd255);
    send_pixel(12'd0, 12'd0);
    send_pixel(COORD_MAX, COORD_MAX);
    drain_pixels();
    program_window(S32_MIN, S32_MAX, STEP_MAX, STEP_MAX, STEP_MAX, 8'd255);
    send_pixel(COORD_MAX, 12'd0);
    drain_pixels();

    // real part of z clamps high on the first update
    program_window(FX_ONE * 11 / 2, 0, 0, 0, STEP_MAX, 8'd255);
    send_pixel(12'd0, 12'd0);
    drain_pixels();

    // squared magnitude passes the threshold at the first compare, so the pixel escapes with no update
    program_window(4 * FX_ONE, -4 * FX_ONE, 0, 0, STEP_MAX, 8'd255);
    send_pixel(12'd7, 12'd9);
    drain_pixels();

    // spare indexes, then zero threshold with a single step
    write_reg(CFG_SPARE_LO, $urandom);
    write_reg(CFG_SPARE_HI, $urandom);
    program_window(0, 0, 1 << 20, 1, 0, 8'd1);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd1, 12'd0);
    drain_pixels();

    // random windows, near the set or anywhere
    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      if (ph % 3 == 2) begin
        lx    = $urandom;
        ty    = $urandom;
        sx    = $urandom;
        sy    = $urandom;
        thr   = $urandom;
        iters = 8'($urandom_range(0, 255));
      end else begin
        lx    = $urandom_range(0, 3 * FX_ONE) - 5 * FX_ONE / 2;
        ty    = $urandom_range(0, 3 * FX_ONE) - 3 * FX_ONE / 2;
        sx    = $urandom_range(0, 1 << 15);
        sy    = $urandom_range(0, 1 << 15);
        thr   = $urandom_range(4 * FX_ONE, 12 * FX_ONE);
        iters = (ph == 1) ? 8'd255 : 8'($urandom_range(1, 64));
      end
      program_window(lx, ty, sx, sy, thr, iters);
      idle_pct = (ph == RANDOM_PHASES - 1) ? 0 : 25 * $urandom_range(0, 2);
      for (k = 0; k < PHASE_ITEMS; k++) begin
        // one full stop mid-phase
        if (ph == 3 && k == PHASE_ITEMS / 2) begin
          drain_pixels();
        end
        send_pixel(COORD_BITS'($urandom_range(0, COORD_MAX)),
                   COORD_BITS'($urandom_range(0, COORD_MAX)));
      end
      drain_pixels();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("%0d pixels sent under %0d windows, %0d results compared, %0d failures",
             pixels_sent, windows_set, checked, fail_count);
    $display("covered image corners, zero and full iteration limits, clamped coordinates");
    if (fail_count == 0) begin
      $display("mandelbrot_escape_time_top regression: pass");
    end else begin
      $display("mandelbrot_escape_time_top regression: fail");
    end
    $finish;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("mandelbrot_escape_time_top regression: fail");
      $finish;
    end
  end

endmodule
